// File: rtl/lbd_pkg.sv
// Shared types, constants and helpers of the least-backlog dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package lbd_pkg;

  localparam int MAX_WORKERS = 8;
  localparam int COUNT_BITS  = 16;

  // worker_id and chosen_worker are 3 bits wide, so never more than eight workers
  localparam int ID_LIMIT     = 8;
  localparam int WORKER_LIMIT = (MAX_WORKERS < ID_LIMIT) ? MAX_WORKERS : ID_LIMIT;

  localparam int MODE_W    = 2;
  localparam int WID_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int BACKLOG_W = 16;
  localparam int WCOUNT_W  = 4;

  localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 4'd8;
  localparam logic [WCOUNT_W-1:0] WCOUNT_LIMIT = WCOUNT_W'(WORKER_LIMIT);

  localparam logic [MODE_W-1:0] MODE_DISPATCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAULT    = 2'd2;

  typedef logic signed [COUNT_BITS-1:0] cnt_t;

  localparam cnt_t CNT_NEG1 = '1;
  localparam cnt_t CNT_ONE  = cnt_t'(1);
  localparam cnt_t CNT_ZERO = '0;
  localparam cnt_t CNT_MAX  = {1'b0, {(COUNT_BITS-1){1'b1}}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FATAL   = 3'd1,
    ST_NOCB    = 3'd2,
    ST_RETRY   = 3'd3,
    ST_IGNORED = 3'd4
  } status_e;

  // flags and result of the shared compare/add unit
  typedef struct packed {
    logic a_zero;
    logic a_neg1;
    logic a_neg;
    logic a_max;
    logic a_lt_b;
    cnt_t sum;
  } alu_res_t;

  // counter to 16-bit signed report value, saturating above 32767
  function automatic logic signed [BACKLOG_W-1:0] encode_backlog(cnt_t v);
    logic signed [32:0] w;
    w = 33'(v);
    if (w > 33'sd32767) begin
      return 16'sd32767;
    end
    return w[BACKLOG_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/lbd_if.sv
// Channel interfaces: request, response and worker-count write port.
`timescale 1ns / 1ps
`default_nettype none

interface lbd_req_if;
  logic                        valid;
  logic                        ready;
  logic [lbd_pkg::MODE_W-1:0]  mode;
  logic [lbd_pkg::WID_W-1:0]   worker_id;
  logic                        has_callback;

  modport source (output valid, mode, worker_id, has_callback, input ready);
  modport sink   (input valid, mode, worker_id, has_callback, output ready);
endinterface

interface lbd_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [lbd_pkg::STATUS_W-1:0]         status;
  logic [lbd_pkg::WID_W-1:0]            chosen_worker;
  logic signed [lbd_pkg::BACKLOG_W-1:0] chosen_backlog;

  modport source (output valid, status, chosen_worker, chosen_backlog, input ready);
  modport sink   (input valid, status, chosen_worker, chosen_backlog, output ready);
endinterface

interface lbd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lbd_pkg::WCOUNT_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/lbd_alu.sv
// Shared compare/add unit used by both the scan and the counter update.
`timescale 1ns / 1ps
`default_nettype none

module lbd_alu (
  input  wire lbd_pkg::cnt_t a_i,
  input  wire lbd_pkg::cnt_t b_i,
  input  wire logic          dec_i,
  output lbd_pkg::alu_res_t  res_o
);

  always_comb begin
    res_o.a_zero = (a_i == lbd_pkg::CNT_ZERO);
    res_o.a_neg1 = (a_i == lbd_pkg::CNT_NEG1);
    res_o.a_neg  = a_i[lbd_pkg::COUNT_BITS-1];
    res_o.a_max  = (a_i >= lbd_pkg::CNT_MAX);
    res_o.a_lt_b = (a_i < b_i);
    res_o.sum    = a_i + (dec_i ? lbd_pkg::CNT_NEG1 : lbd_pkg::CNT_ONE);
  end

endmodule

`default_nettype wire

// File: rtl/least_backlog_dispatcher.sv
// Top level: per-worker backlog counters with a sequential least-backlog scan.
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    mode, worker_id, has_callback
//  rsp_o    out  valid/ready    status, chosen_worker, chosen_backlog
//  cfg_i    in   valid/ready    data = worker_count (always ready)
//
// A dispatch with a callback scans the workers in S_SCAN, visiting 1..worker_count of them
// (at most 8); the single counter read port and the shared compare unit visit one worker a
// cycle, then S_APPLY updates the counter and loads the result register once the result slot
// is free.
// Events, dispatches without callback and unused modes go from S_IDLE straight to S_APPLY.
// Reset clears all counters to zero and sets worker_count to 8.
// A held result stalls only the final update; no new request is taken while it waits.
`timescale 1ns / 1ps
`default_nettype none

module least_backlog_dispatcher (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lbd_req_if.sink     req_i,
  lbd_rsp_if.source   rsp_o,
  lbd_cfg_if.sink     cfg_i
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_e;
  typedef enum logic [1:0] {OP_INC, OP_DEC, OP_FAULT, OP_NONE} op_e;

  state_e                          state_q;
  op_e                             op_q;
  logic [lbd_pkg::WID_W-1:0]       idx_q;
  logic [lbd_pkg::WID_W-1:0]       pick_q;
  lbd_pkg::cnt_t                   best_q;
  lbd_pkg::status_e                pre_st_q;
  lbd_pkg::cnt_t                   cnt_q [lbd_pkg::MAX_WORKERS];
  logic [lbd_pkg::WCOUNT_W-1:0]    wc_q;

  logic                            out_valid_q;
  lbd_pkg::status_e                out_st_q;
  logic [lbd_pkg::WID_W-1:0]       out_w_q;
  logic signed [lbd_pkg::BACKLOG_W-1:0] out_b_q;

  logic [lbd_pkg::WCOUNT_W-1:0]    n_eff;
  lbd_pkg::cnt_t                   rd_val;
  lbd_pkg::alu_res_t               alu;
  logic                            req_fire;
  logic                            slot_free;
  logic                            cand;
  logic                            last;
  logic                            id_out;

  assign req_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !out_valid_q || rsp_o.ready;

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_st_q;
  assign rsp_o.chosen_worker  = out_w_q;
  assign rsp_o.chosen_backlog = out_b_q;

  always_comb begin
    if (wc_q == '0) begin
      n_eff = lbd_pkg::WCOUNT_W'(1);
    end else if (wc_q > lbd_pkg::WCOUNT_LIMIT) begin
      n_eff = lbd_pkg::WCOUNT_LIMIT;
    end else begin
      n_eff = wc_q;
    end
  end

  // single read port on the counter file
  assign rd_val = cnt_q[idx_q];

  lbd_alu u_alu (
    .a_i   (rd_val),
    .b_i   (best_q),
    .dec_i (op_q == OP_DEC),
    .res_o (alu)
  );

  assign cand   = (idx_q == '0) || alu.a_zero || alu.a_lt_b;
  assign last   = ({1'b0, idx_q} + lbd_pkg::WCOUNT_W'(1)) >= n_eff;
  assign id_out = {1'b0, req_i.worker_id} >= n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      idx_q       <= '0;
      wc_q        <= lbd_pkg::WCOUNT_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < lbd_pkg::MAX_WORKERS; i++) begin
        cnt_q[i] <= lbd_pkg::CNT_ZERO;
      end
    end else begin
      if (cfg_i.valid) begin
        wc_q <= cfg_i.data;
      end
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            case (req_i.mode)
              lbd_pkg::MODE_DISPATCH: begin
                idx_q <= '0;
                if (req_i.has_callback) begin
                  op_q    <= OP_INC;
                  state_q <= S_SCAN;
                end else begin
                  op_q     <= OP_NONE;
                  pre_st_q <= lbd_pkg::ST_NOCB;
                  state_q  <= S_APPLY;
                end
              end
              lbd_pkg::MODE_COMPLETE, lbd_pkg::MODE_FAULT: begin
                idx_q    <= req_i.worker_id;
                pre_st_q <= lbd_pkg::ST_IGNORED;
                state_q  <= S_APPLY;
                if (id_out) begin
                  op_q <= OP_NONE;
                end else if (req_i.mode == lbd_pkg::MODE_FAULT) begin
                  op_q <= OP_FAULT;
                end else begin
                  op_q <= OP_DEC;
                end
              end
              default: begin
                idx_q    <= '0;
                op_q     <= OP_NONE;
                pre_st_q <= lbd_pkg::ST_IGNORED;
                state_q  <= S_APPLY;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (cand) begin
            pick_q <= idx_q;
            best_q <= rd_val;
          end
          // stop once the choice has zero backlog or the last worker is seen
          if ((cand && alu.a_zero) || last) begin
            idx_q   <= cand ? idx_q : pick_q;
            state_q <= S_APPLY;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_APPLY: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_w_q     <= idx_q;
            state_q     <= S_IDLE;
            case (op_q)
              OP_INC: begin
                if (alu.a_neg1) begin
                  out_st_q <= lbd_pkg::ST_FATAL;
                  out_b_q  <= lbd_pkg::encode_backlog(lbd_pkg::CNT_NEG1);
                end else if (alu.a_max) begin
                  out_st_q <= lbd_pkg::ST_RETRY;
                  out_b_q  <= lbd_pkg::encode_backlog(rd_val);
                end else begin
                  cnt_q[idx_q] <= alu.sum;
                  out_st_q     <= lbd_pkg::ST_OK;
                  out_b_q      <= lbd_pkg::encode_backlog(alu.sum);
                end
              end
              OP_DEC: begin
                if (alu.a_zero || alu.a_neg) begin
                  out_st_q <= lbd_pkg::ST_IGNORED;
                  out_b_q  <= lbd_pkg::encode_backlog(rd_val);
                end else begin
                  cnt_q[idx_q] <= alu.sum;
                  out_st_q     <= lbd_pkg::ST_OK;
                  out_b_q      <= lbd_pkg::encode_backlog(alu.sum);
                end
              end
              OP_FAULT: begin
                cnt_q[idx_q] <= lbd_pkg::CNT_NEG1;
                out_st_q     <= lbd_pkg::ST_OK;
                out_b_q      <= lbd_pkg::encode_backlog(lbd_pkg::CNT_NEG1);
              end
              default: begin
                out_st_q <= pre_st_q;
                out_b_q  <= '0;
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready)
    else $error("request taken while a transaction is in progress");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ({1'b0, idx_q} < n_eff))
    else $error("scan index past the workers in use");

  a_fatal_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q == lbd_pkg::ST_FATAL) |-> (out_b_q == -16'sd1))
    else $error("fatal result without faulted backlog");

  a_counter_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY || state_q == S_SCAN) |-> (rd_val >= lbd_pkg::CNT_NEG1))
    else $error("backlog counter below the faulted value");

endmodule

`default_nettype wire
